// File: rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and constants for the triangle scanline rasterizer
// Widths of the fixed-point edge values and the sequencer's state codes.
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int SCREEN_ROWS_DEF = 63;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int ROW_W           = 6;
    localparam int COL_W           = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT,
        ST_DIVM,
        ST_MULM,
        ST_DIVA1,
        ST_DIVB1,
        ST_EMIT1,
        ST_DIVA2,
        ST_DIVB2,
        ST_EMIT2
    } tsr_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } tsr_div_ctl_t;

endpackage

// File: rtl/tsr_divider.sv
// ----------------------------------------------------------------------------
// tsr_divider: shared iterative signed divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module tsr_divider
    import tsr_pkg::*;
#(
    parameter int NUM_W = 26
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [ROW_W-1:0]        den,
    output tsr_div_ctl_t            ctl,
    output logic signed [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] mag_reg, mag_next;
    logic [ROW_W:0]   rem_reg, rem_next;
    logic [ROW_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [ROW_W:0]   trial;
    logic [ROW_W:0]   shifted;

    always_comb begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[ROW_W-1:0], mag_reg[NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start) begin
            neg_next  = num[NUM_W-1];
            mag_next  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[ROW_W]) begin
                rem_next = trial;
                mag_next = {mag_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                mag_next = {mag_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign quot      = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
endmodule

// File: rtl/triangle_scanline_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// triangle_scanline_rasterizer_unit: scanline triangle rasterizer
// Splits a triangle at its middle vertex and walks both halves row by row.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one triangle word (three vertices plus fill code).
//   m_ channel returns one span word per row: row, left, right, fill code,
//   with m_tlast high on the final span (always the middle vertex's row).
//   A triangle gives hi.y - lo.y + 2 spans.
// Timing:
//   One shared restoring divider does up to five divisions: the cut point,
//   then two slopes per half. The cut point also passes through the
//   multiply state MULM. A half of zero height skips its two divisions.
//   Spans leave at one per cycle while m_tready is high.
//   s_tready is high only while idle; one triangle is in work at a time.
// Reset: aresetn (sync, active low) returns the sequencer to idle and drops
//   m_tvalid. Stall: m_tvalid and the span word hold until m_tready; the
//   edge walk waits with them.
// ----------------------------------------------------------------------------
module triangle_scanline_rasterizer_unit
    import tsr_pkg::*;
#(
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // a_x[7:0] a_y[13:8] b_x[21:14] b_y[27:22] c_x[35:28] c_y[41:36] fill[49:42]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // span_row[5:0] span_left[13:6] span_right[21:14] span_char[29:22]
    output logic [31:0] m_tdata,
    output logic        m_tlast
);
    // edge value: sign + 9 integer bits + fraction
    localparam int Q_W = FRAC_BITS + COL_W + 2;
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(SCREEN_ROWS - 1);

    tsr_state_t state_reg, state_next;

    logic [COL_W-1:0] px_reg [3];
    logic [ROW_W-1:0] py_reg [3];
    logic [COL_W-1:0] ch_reg;
    logic signed [Q_W-1:0] qm_reg, sa_reg, ea_reg, eb_reg, dm_reg;
    logic [ROW_W-1:0] row_reg, cnt_reg;
    logic             div_go;
    logic signed [Q_W-1:0] div_num;
    logic [ROW_W-1:0] div_den;
    tsr_div_ctl_t     dctl;
    logic signed [Q_W-1:0] div_q;

    logic [ROW_W-1:0] d01, d12, d02;
    logic signed [Q_W-1:0] q0, q1, q2;
    logic signed [Q_W-1:0] qm_calc;
    logic [ROW_W-1:0] ry [3];
    logic [COL_W-1:0] rx [3];

    function automatic logic [ROW_W-1:0] sat_row(input logic [ROW_W-1:0] y);
        return (y > ROW_MAX) ? ROW_MAX : y;
    endfunction

    function automatic logic [COL_W-1:0] col_of(input logic signed [Q_W-1:0] q);
        logic [Q_W-FRAC_BITS-1:0] ip;
        ip = q[Q_W-1:FRAC_BITS];
        if (q[Q_W-1])
            return '0;
        else if (ip[Q_W-FRAC_BITS-2:COL_W] != '0)
            return '1;
        else
            return ip[COL_W-1:0];
    endfunction

    assign d01 = py_reg[1] - py_reg[0];
    assign d12 = py_reg[2] - py_reg[1];
    assign d02 = py_reg[2] - py_reg[0];
    assign q0  = Q_W'({px_reg[0], {FRAC_BITS{1'b0}}});
    assign q1  = Q_W'({px_reg[1], {FRAC_BITS{1'b0}}});
    assign q2  = Q_W'({px_reg[2], {FRAC_BITS{1'b0}}});

    // cut point on the long edge: q0 + cut slope * (mid.y - lo.y)
    assign qm_calc = q0 + Q_W'(dm_reg * $signed({1'b0, d01}));

    tsr_divider #(.NUM_W(Q_W)) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_go),
        .num    (div_num),
        .den    (div_den),
        .ctl    (dctl),
        .quot   (div_q)
    );

    // stable 3-element sort network on saturated rows
    always_comb begin
        logic [ROW_W-1:0] ty;
        logic [COL_W-1:0] tx;
        ty = '0;
        tx = '0;
        for (int i = 0; i < 3; i++) begin
            rx[i] = s_tdata[14*i +: COL_W];
            ry[i] = sat_row(s_tdata[14*i+COL_W +: ROW_W]);
        end
        if (ry[0] > ry[1]) begin
            ty = ry[0]; ry[0] = ry[1]; ry[1] = ty;
            tx = rx[0]; rx[0] = rx[1]; rx[1] = tx;
        end
        if (ry[1] > ry[2]) begin
            ty = ry[1]; ry[1] = ry[2]; ry[2] = ty;
            tx = rx[1]; rx[1] = rx[2]; rx[2] = tx;
        end
        if (ry[0] > ry[1]) begin
            ty = ry[0]; ry[0] = ry[1]; ry[1] = ty;
            tx = rx[0]; rx[0] = rx[1]; rx[1] = tx;
        end
    end

    logic [COL_W-1:0] ca, cb;
    assign ca = col_of(ea_reg);
    assign cb = col_of(eb_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT1) || (state_reg == ST_EMIT2);
    assign m_tlast  = (state_reg == ST_EMIT2) && (cnt_reg == '0);
    assign m_tdata  = {2'b00, ch_reg, (ca > cb) ? ca : cb, (ca > cb) ? cb : ca, row_reg};

    always_comb begin
        state_next = state_reg;
        div_go     = 1'b0;
        div_num    = '0;
        div_den    = '0;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_SORT;
            ST_SORT: begin
                if (d02 != '0) begin
                    div_go = 1'b1; div_num = q2 - q0; div_den = d02;
                end
                state_next = ST_DIVM;
            end
            ST_DIVM: if (d02 == '0 || dctl.done) state_next = ST_MULM;
            ST_MULM: begin
                if (d01 != '0) begin
                    div_go = 1'b1; div_num = qm_calc - q0; div_den = d01;
                end
                state_next = ST_DIVA1;
            end
            ST_DIVA1: begin
                if (d01 == '0 || dctl.done) begin
                    if (d01 != '0) begin
                        div_go = 1'b1; div_num = q1 - q0; div_den = d01;
                    end
                    state_next = ST_DIVB1;
                end
            end
            ST_DIVB1: if (d01 == '0 || dctl.done) state_next = ST_EMIT1;
            ST_EMIT1: if (m_tready && cnt_reg == '0) begin
                if (d12 != '0) begin
                    div_go = 1'b1; div_num = q2 - qm_reg; div_den = d12;
                end
                state_next = ST_DIVA2;
            end
            ST_DIVA2: begin
                if (d12 == '0 || dctl.done) begin
                    if (d12 != '0) begin
                        div_go = 1'b1; div_num = q2 - q1; div_den = d12;
                    end
                    state_next = ST_DIVB2;
                end
            end
            ST_DIVB2: if (d12 == '0 || dctl.done) state_next = ST_EMIT2;
            ST_EMIT2: if (m_tready && cnt_reg == '0) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath; MULM uses dm_reg (cut slope) times d01
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                for (int i = 0; i < 3; i++) begin
                    px_reg[i] <= rx[i];
                    py_reg[i] <= ry[i];
                end
                ch_reg <= s_tdata[49:42];
            end
            ST_SORT: dm_reg <= '0;
            ST_DIVM: if (d02 != '0 && dctl.done) dm_reg <= div_q;
            ST_MULM: qm_reg <= qm_calc;
            ST_DIVA1: begin
                sa_reg <= '0;
                if (d01 != '0 && dctl.done) sa_reg <= div_q;
                if (d01 == '0) sa_reg <= '0;
            end
            ST_DIVB1: if (d01 == '0 || dctl.done) begin
                ea_reg  <= q0;
                eb_reg  <= q0;
                row_reg <= py_reg[0];
                cnt_reg <= d01;
                dm_reg  <= (d01 != '0) ? div_q : '0;
            end
            ST_EMIT1: if (m_tready) begin
                ea_reg  <= ea_reg + sa_reg;
                eb_reg  <= eb_reg + dm_reg;
                row_reg <= row_reg + 1'b1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_DIVA2: if (d12 == '0 || dctl.done)
                sa_reg <= (d12 != '0) ? div_q : '0;
            ST_DIVB2: if (d12 == '0 || dctl.done) begin
                ea_reg  <= q2;
                eb_reg  <= q2;
                row_reg <= py_reg[2];
                cnt_reg <= d12;
                dm_reg  <= (d12 != '0) ? div_q : '0;
            end
            ST_EMIT2: if (m_tready) begin
                ea_reg  <= ea_reg - sa_reg;
                eb_reg  <= eb_reg - dm_reg;
                row_reg <= row_reg - 1'b1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("ready while emitting");
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[5:0] == py_reg[1]))
        else $error("last span not on middle row");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("span changed under stall");
endmodule
